/* rtl/gpsm_pkg.sv */
// shared types, constants and codes for the greedy path sequence matcher
package gpsm_pkg;

    localparam int NUM_PATHS    = 32;
    localparam int MAX_PATH_LEN = 16;
    localparam int ID_BITS      = 16;

    localparam int SLOT_W = $clog2(NUM_PATHS);
    localparam int POS_W  = $clog2(MAX_PATH_LEN);
    localparam int FILL_W = $clog2(MAX_PATH_LEN + 1);

    // request opcodes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_VISIT = 2'd1;
    localparam logic [1:0] OP_FLUSH = 2'd2;

    // result kinds
    localparam logic [1:0] KIND_MATCH     = 2'd0;
    localparam logic [1:0] KIND_UNMATCHED = 2'd1;
    localparam logic [1:0] KIND_NONE      = 2'd2;

    typedef logic [ID_BITS-1:0]                    t_id;
    typedef logic [MAX_PATH_LEN-1:0][ID_BITS-1:0] t_row;
    typedef logic [SLOT_W-1:0]                     t_slot;
    typedef logic [FILL_W-1:0]                     t_fill;

    typedef struct packed {
        logic [1:0]  op;
        logic [4:0]  path_index;
        logic [3:0]  path_position;
        logic [4:0]  path_length;
        logic [15:0] path_image;
        logic [15:0] hotspot_id;
        logic [62:0] entry_time;
        logic [62:0] exit_time;
        logic [15:0] visit_image;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  kind;
        logic [4:0]  matched_path;
        logic [31:0] first_visit;
        logic [4:0]  visit_count;
        logic [62:0] start_time;
        logic [62:0] end_time;
        logic [15:0] visit_id;
        logic [15:0] image_index;
        logic        last;
    } t_out_item;

    // window head entry
    typedef struct packed {
        t_id         id;
        logic [62:0] entry_time;
        logic [62:0] exit_time;
        logic [15:0] image;
    } t_win_entry;

    // window control from the sequencer
    typedef struct packed {
        logic push;
        logic shift;
        logic clear;
    } t_win_ctl;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_EMIT,
        ST_MARK
    } t_state;

endpackage

/* rtl/gpsm_path_table.sv */
// path table: id rows in a memory, lengths and images in registers
module gpsm_path_table (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_we,
    input  gpsm_pkg::t_slot       i_widx,
    input  logic [3:0]            i_wpos,
    input  logic [4:0]            i_wlen,
    input  logic [15:0]           i_wimage,
    input  gpsm_pkg::t_id         i_wid,
    input  logic                  i_re,
    input  gpsm_pkg::t_slot       i_raddr,
    output gpsm_pkg::t_row        o_row,
    output gpsm_pkg::t_fill       o_len,
    output logic [15:0]           o_image
);

    gpsm_pkg::t_row  r_mem [gpsm_pkg::NUM_PATHS];
    gpsm_pkg::t_fill r_len [gpsm_pkg::NUM_PATHS];
    logic [15:0]     r_img [gpsm_pkg::NUM_PATHS];
    gpsm_pkg::t_row  r_row;
    gpsm_pkg::t_fill r_rlen;
    logic [15:0]     r_rimg;
    gpsm_pkg::t_fill w_len;

    // saturate overlong lengths
    always_comb begin
        if (i_wlen > 5'(gpsm_pkg::MAX_PATH_LEN)) begin
            w_len = gpsm_pkg::t_fill'(gpsm_pkg::MAX_PATH_LEN);
        end else begin
            w_len = gpsm_pkg::t_fill'(i_wlen);
        end
    end

    // id memory, one element written, one row read
    always_ff @(posedge i_clk) begin
        if (i_we && (32'(i_wpos) < 32'(gpsm_pkg::MAX_PATH_LEN))) begin
            r_mem[i_widx][i_wpos[gpsm_pkg::POS_W-1:0]] <= i_wid;
        end
        if (i_re) begin
            r_row <= r_mem[i_raddr];
        end
    end

    // lengths and images, cleared by reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < gpsm_pkg::NUM_PATHS; i++) begin
                r_len[i] <= '0;
                r_img[i] <= '0;
            end
        end else if (i_we && (32'(i_wpos) < 32'(gpsm_pkg::MAX_PATH_LEN))) begin
            r_len[i_widx] <= w_len;
            r_img[i_widx] <= i_wimage;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rlen <= r_len[i_raddr];
            r_rimg <= r_img[i_raddr];
        end
    end

    assign o_row   = r_row;
    assign o_len   = r_rlen;
    assign o_image = r_rimg;

endmodule

/* rtl/gpsm_window.sv */
// visit window: shift line of held visits and the shared row compare unit
module gpsm_window (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  gpsm_pkg::t_win_ctl     i_ctl,
    input  gpsm_pkg::t_win_entry   i_visit,
    input  gpsm_pkg::t_row         i_row,
    input  gpsm_pkg::t_fill        i_len,
    output gpsm_pkg::t_fill        o_fill,
    output gpsm_pkg::t_win_entry   o_head,
    output logic                   o_hit
);

    gpsm_pkg::t_win_entry r_win [gpsm_pkg::MAX_PATH_LEN];
    gpsm_pkg::t_fill      r_fill;
    logic                 w_hit;

    // fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
        end else if (i_ctl.clear) begin
            r_fill <= '0;
        end else if (i_ctl.push) begin
            r_fill <= r_fill + 1'b1;
        end else if (i_ctl.shift && (r_fill != '0)) begin
            r_fill <= r_fill - 1'b1;
        end
    end

    // entries: append at the tail, advance toward the head
    always_ff @(posedge i_clk) begin
        if (i_ctl.push) begin
            r_win[r_fill[gpsm_pkg::POS_W-1:0]] <= i_visit;
        end else if (i_ctl.shift) begin
            for (int i = 0; i < gpsm_pkg::MAX_PATH_LEN - 1; i++) begin
                r_win[i] <= r_win[i + 1];
            end
        end
    end

    // compare one path row against the leading visits
    always_comb begin
        w_hit = (i_len >= gpsm_pkg::t_fill'(2)) && (i_len <= r_fill);
        for (int i = 0; i < gpsm_pkg::MAX_PATH_LEN; i++) begin
            if ((gpsm_pkg::t_fill'(i) < i_len) && (i_row[i] != r_win[i].id)) begin
                w_hit = 1'b0;
            end
        end
    end

    assign o_fill = r_fill;
    assign o_head = r_win[0];
    assign o_hit  = w_hit;

endmodule

/* rtl/greedy_path_sequence_matcher.sv */
// top level: request sequencer, path scan and result register
//
// channel | direction | handshake           | payload
// in      | input     | i_in_valid/o_in_stall  | i_in_item  (t_in_item)
// out     | output    | o_out_valid/i_out_stall| o_out_item (t_out_item)
// cfg     | input     | i_cfg_valid/o_cfg_ready| i_cfg_data (report_unmatched)
//
// a load, or a visit that leaves the window short of full, is taken in the idle state;
// a head decision scans the path table one path per cycle through the row
// read port, then shifts the window one entry a cycle (up to
// MAX_PATH_LEN - 1), settles the new head and waits for the result register.
// a flush repeats decisions until the window is empty, then sends a marker.
// reset is synchronous; path lengths and images are clear in the reset cycle, no sweep; id rows are not reset.
// a stalled output holds the sequencer; o_in_stall is high while busy.
module greedy_path_sequence_matcher (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    input  gpsm_pkg::t_in_item   i_in_item,
    output logic                 o_in_stall,
    output logic                 o_out_valid,
    output gpsm_pkg::t_out_item  o_out_item,
    input  logic                 i_out_stall,
    input  logic                 i_cfg_valid,
    input  logic                 i_cfg_data,
    output logic                 o_cfg_ready
);

    gpsm_pkg::t_state     r_state, n_state;
    logic                 r_report;
    logic                 r_closed, n_closed;
    logic                 r_flush, n_flush;
    logic [31:0]          r_seq;
    gpsm_pkg::t_slot      r_issue, n_issue;
    logic                 r_issued_all, n_issued_all;
    gpsm_pkg::t_slot      r_cmp_p, n_cmp_p;
    logic                 r_cmp_v, n_cmp_v;
    logic [3:0]           r_shift, n_shift;
    logic                 r_emit, n_emit;
    gpsm_pkg::t_out_item  r_res, n_res;
    logic                 r_out_valid, n_out_valid;
    gpsm_pkg::t_out_item  r_out, n_out;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_tbl_we;
    logic                 w_tbl_re;
    gpsm_pkg::t_row       w_row;
    gpsm_pkg::t_fill      w_len;
    logic [15:0]          w_image;
    gpsm_pkg::t_win_ctl   w_ctl;
    gpsm_pkg::t_win_entry w_visit;
    gpsm_pkg::t_fill      w_fill;
    gpsm_pkg::t_win_entry w_head;
    logic                 w_hit;
    gpsm_pkg::t_state     w_after;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state != gpsm_pkg::ST_IDLE);
    assign o_cfg_ready = 1'b1;
    assign w_tbl_we   = w_accept && (i_in_item.op == gpsm_pkg::OP_LOAD);

    assign w_visit.id         = gpsm_pkg::t_id'(i_in_item.hotspot_id);
    assign w_visit.entry_time = i_in_item.entry_time;
    assign w_visit.exit_time  = i_in_item.exit_time;
    assign w_visit.image      = i_in_item.visit_image;

    gpsm_path_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_we     (w_tbl_we),
        .i_widx   (gpsm_pkg::t_slot'(i_in_item.path_index)),
        .i_wpos   (i_in_item.path_position),
        .i_wlen   (i_in_item.path_length),
        .i_wimage (i_in_item.path_image),
        .i_wid    (gpsm_pkg::t_id'(i_in_item.hotspot_id)),
        .i_re     (w_tbl_re),
        .i_raddr  (r_issue),
        .o_row    (w_row),
        .o_len    (w_len),
        .o_image  (w_image)
    );

    gpsm_window u_window (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_visit (w_visit),
        .i_row   (w_row),
        .i_len   (w_len),
        .o_fill  (w_fill),
        .o_head  (w_head),
        .o_hit   (w_hit)
    );

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_report <= 1'b0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_report <= i_cfg_data;
        end
    end

    // visit sequence counter
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seq <= '0;
        end else if (w_accept && (i_in_item.op == gpsm_pkg::OP_VISIT)) begin
            r_seq <= r_seq + 32'd1;
        end
    end

    // state and control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= gpsm_pkg::ST_IDLE;
            r_closed     <= 1'b0;
            r_flush      <= 1'b0;
            r_issue      <= '0;
            r_issued_all <= 1'b0;
            r_cmp_v      <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_closed     <= n_closed;
            r_flush      <= n_flush;
            r_issue      <= n_issue;
            r_issued_all <= n_issued_all;
            r_cmp_v      <= n_cmp_v;
            r_out_valid  <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_cmp_p <= n_cmp_p;
        r_shift <= n_shift;
        r_emit  <= n_emit;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    // where to go once a decision is finished
    always_comb begin
        if (!r_flush) begin
            w_after = gpsm_pkg::ST_IDLE;
        end else if (w_fill != '0) begin
            w_after = gpsm_pkg::ST_SCAN;
        end else begin
            w_after = gpsm_pkg::ST_MARK;
        end
    end

    // sequencer
    always_comb begin
        n_state      = r_state;
        n_closed     = r_closed;
        n_flush      = r_flush;
        n_issue      = r_issue;
        n_issued_all = r_issued_all;
        n_cmp_p      = r_cmp_p;
        n_cmp_v      = r_cmp_v;
        n_shift      = r_shift;
        n_emit       = r_emit;
        n_res        = r_res;
        n_out        = r_out;
        n_out_valid  = r_out_valid && i_out_stall;
        w_ctl        = '0;
        w_tbl_re     = 1'b0;

        unique case (r_state)
            gpsm_pkg::ST_IDLE: begin
                n_issue      = '0;
                n_issued_all = 1'b0;
                n_cmp_v      = 1'b0;
                if (w_accept) begin
                    priority if (i_in_item.op == gpsm_pkg::OP_VISIT) begin
                        w_ctl.push = 1'b1;
                        if (w_fill == gpsm_pkg::t_fill'(gpsm_pkg::MAX_PATH_LEN - 1)) begin
                            n_state = gpsm_pkg::ST_SCAN;
                        end
                    end else if (i_in_item.op == gpsm_pkg::OP_FLUSH) begin
                        n_flush = 1'b1;
                        n_state = (w_fill != '0) ? gpsm_pkg::ST_SCAN : gpsm_pkg::ST_MARK;
                    end else begin
                        n_state = gpsm_pkg::ST_IDLE;
                    end
                end
            end

            gpsm_pkg::ST_SCAN: begin
                n_res.matched_path = '0;
                n_res.first_visit  = r_seq - 32'(w_fill);
                n_res.last         = 1'b0;
                if (r_cmp_v && w_hit) begin
                    // first hit in table order wins
                    n_res.kind         = gpsm_pkg::KIND_MATCH;
                    n_res.matched_path = 5'(r_cmp_p);
                    n_res.visit_count  = 5'(w_len);
                    n_res.start_time   = w_head.exit_time;
                    n_res.end_time     = w_head.entry_time;
                    n_res.visit_id     = '0;
                    n_res.image_index  = w_image;
                    n_shift            = 4'(w_len - 1'b1);
                    n_emit             = 1'b1;
                    n_closed           = 1'b1;
                    n_state            = gpsm_pkg::ST_SHIFT;
                end else if (r_cmp_v && (r_cmp_p == gpsm_pkg::t_slot'(gpsm_pkg::NUM_PATHS - 1)))
                begin
                    // no path fits: drop the head visit
                    n_res.kind        = gpsm_pkg::KIND_UNMATCHED;
                    n_res.visit_count = 5'd1;
                    n_res.start_time  = w_head.entry_time;
                    n_res.end_time    = w_head.exit_time;
                    n_res.visit_id    = 16'(w_head.id);
                    n_res.image_index = w_head.image;
                    n_shift           = 4'd1;
                    n_emit            = r_report && !r_closed;
                    n_closed          = 1'b0;
                    n_state           = gpsm_pkg::ST_SHIFT;
                end else if (!r_issued_all) begin
                    w_tbl_re = 1'b1;
                    n_cmp_p  = r_issue;
                    n_cmp_v  = 1'b1;
                    n_issue  = r_issue + 1'b1;
                    if (r_issue == gpsm_pkg::t_slot'(gpsm_pkg::NUM_PATHS - 1)) begin
                        n_issued_all = 1'b1;
                    end
                end
            end

            gpsm_pkg::ST_SHIFT: begin
                n_issue      = '0;
                n_issued_all = 1'b0;
                n_cmp_v      = 1'b0;
                if (r_shift != '0) begin
                    w_ctl.shift = 1'b1;
                    n_shift     = r_shift - 1'b1;
                end else begin
                    // new head is the last covered visit of a match
                    if (r_res.kind == gpsm_pkg::KIND_MATCH) begin
                        n_res.end_time = w_head.entry_time;
                    end
                    n_state = r_emit ? gpsm_pkg::ST_EMIT : w_after;
                end
            end

            gpsm_pkg::ST_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out.last  = !r_flush;
                    n_out_valid = 1'b1;
                    n_state     = w_after;
                end
            end

            gpsm_pkg::ST_MARK: begin
                if (w_out_free) begin
                    n_out       = '0;
                    n_out.kind  = gpsm_pkg::KIND_NONE;
                    n_out.last  = 1'b1;
                    n_out_valid = 1'b1;
                    w_ctl.clear = 1'b1;
                    n_closed    = 1'b0;
                    n_flush     = 1'b0;
                    n_state     = gpsm_pkg::ST_IDLE;
                end
            end

            default: begin
                n_state = gpsm_pkg::ST_IDLE;
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

`ifndef SYNTH
    // window never holds more than one full path of visits
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_fill <= gpsm_pkg::t_fill'(gpsm_pkg::MAX_PATH_LEN))
        else $error("window fill overflow");

    // a flush marker always closes its request
    a_marker_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_item.kind == gpsm_pkg::KIND_NONE)) |-> o_out_item.last)
        else $error("marker without last");

    // sending the marker empties the window
    a_mark_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == gpsm_pkg::ST_MARK) && w_out_free) |=> (w_fill == '0))
        else $error("window not empty after flush");
`endif

endmodule

/* bench/greedy_path_sequence_matcher_test.sv */
// testbench for the greedy path sequence matcher: directed table, random phases, event scoreboard
module greedy_path_sequence_matcher_test;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int SETTLE       = 120;
    localparam int PHASE_ITEMS  = 75;
    localparam int MAX_REPORTED = 10;

    logic                i_clk;
    logic                i_rst_n;
    logic                i_in_valid;
    gpsm_pkg::t_in_item  i_in_item;
    logic                o_in_stall;
    logic                o_out_valid;
    gpsm_pkg::t_out_item o_out_item;
    logic                i_out_stall;
    logic                i_cfg_valid;
    logic                i_cfg_data;
    logic                o_cfg_ready;

    greedy_path_sequence_matcher u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready)
    );

    // clock
    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // matcher state mirror
    logic [15:0]          path_id_tab [gpsm_pkg::NUM_PATHS][gpsm_pkg::MAX_PATH_LEN];
    logic [4:0]           path_len_tab [gpsm_pkg::NUM_PATHS];
    logic [15:0]          path_img_tab [gpsm_pkg::NUM_PATHS];
    logic [15:0]          path_written [gpsm_pkg::NUM_PATHS];
    gpsm_pkg::t_win_entry window [gpsm_pkg::MAX_PATH_LEN];
    int                   window_fill;
    bit                   head_closed;
    logic [31:0]          visit_seq;
    bit                   report_unmatched;

    gpsm_pkg::t_out_item  pending_events [$];
    int          mismatches;
    int          items_sent;
    int          events_seen;
    int          matches_seen;
    int          unmatched_seen;
    int          in_idle_pct;
    int          out_stall_pct;
    int          cycles;

    // appends one expected event at the tail of the scoreboard
    function automatic void queue_event(gpsm_pkg::t_out_item ev);
        pending_events.insert(pending_events.size(), ev);
    endfunction

    function automatic void drop_window(int n);
        if (n > window_fill) n = window_fill;
        for (int i = 0; i + n < window_fill; i++) window[i] = window[i + n];
        window_fill -= n;
    endfunction

    // one head decision; returns 1 when an event is produced
    function automatic bit decide_head(output gpsm_pkg::t_out_item ev);
        logic [31:0] first;
        int          len;
        bit          hit;
        first = visit_seq - 32'(window_fill);
        ev = '0;
        for (int p = 0; p < gpsm_pkg::NUM_PATHS; p++) begin
            len = int'(path_len_tab[p]);
            if (len < 2 || len > window_fill) continue;
            hit = 1'b1;
            for (int i = 0; i < len; i++)
                if (path_id_tab[p][i] != window[i].id) hit = 1'b0;
            if (hit) begin
                ev.kind         = gpsm_pkg::KIND_MATCH;
                ev.matched_path = p[4:0];
                ev.first_visit  = first;
                ev.visit_count  = len[4:0];
                ev.start_time   = window[0].exit_time;
                ev.end_time     = window[len - 1].entry_time;
                ev.image_index  = path_img_tab[p];
                drop_window(len - 1);
                head_closed = 1'b1;
                return 1'b1;
            end
        end
        hit = report_unmatched && !head_closed;
        if (hit) begin
            ev.kind        = gpsm_pkg::KIND_UNMATCHED;
            ev.first_visit = first;
            ev.visit_count = 5'd1;
            ev.start_time  = window[0].entry_time;
            ev.end_time    = window[0].exit_time;
            ev.visit_id    = window[0].id;
            ev.image_index = window[0].image;
        end
        drop_window(1);
        head_closed = 1'b0;
        return hit;
    endfunction

    // works out the events an accepted request causes, appends them to the scoreboard
    function automatic int predict_events(gpsm_pkg::t_in_item it);
        gpsm_pkg::t_out_item ev;
        int                  n;
        n = 0;
        case (it.op)
            gpsm_pkg::OP_LOAD: begin
                path_id_tab[it.path_index][it.path_position] = it.hotspot_id;
                path_len_tab[it.path_index] = (it.path_length > gpsm_pkg::MAX_PATH_LEN) ?
                                              5'(gpsm_pkg::MAX_PATH_LEN) : it.path_length;
                path_img_tab[it.path_index] = it.path_image;
            end
            gpsm_pkg::OP_VISIT: begin
                if (window_fill < gpsm_pkg::MAX_PATH_LEN) begin
                    window[window_fill] = '{it.hotspot_id, it.entry_time,
                                            it.exit_time, it.visit_image};
                    window_fill++;
                end
                visit_seq++;
                if (window_fill >= gpsm_pkg::MAX_PATH_LEN && decide_head(ev)) begin
                    ev.last = 1'b1;
                    queue_event(ev);
                    n = 1;
                end
            end
            gpsm_pkg::OP_FLUSH: begin
                while (window_fill > 0 && n < gpsm_pkg::MAX_PATH_LEN) begin
                    if (decide_head(ev)) begin
                        queue_event(ev);
                        n++;
                    end
                end
                window_fill = 0;
                head_closed = 1'b0;
                ev = '0;
                ev.kind = gpsm_pkg::KIND_NONE;
                ev.last = 1'b1;
                queue_event(ev);
                n++;
            end
            default: ;
        endcase
        return n;
    endfunction

    // number of leading path positions already written, counting a pending write
    function automatic int written_prefix(int slot, int pos);
        logic [15:0] m;
        int          k;
        m = path_written[slot] | (16'd1 << pos);
        k = 0;
        while (k < gpsm_pkg::MAX_PATH_LEN && m[k]) k++;
        return k;
    endfunction

    function automatic gpsm_pkg::t_in_item load_req(int slot, int pos, int len,
                                                    logic [15:0] id, logic [15:0] img);
        gpsm_pkg::t_in_item it;
        int                 eff;
        it = '0;
        eff = (len > gpsm_pkg::MAX_PATH_LEN) ? gpsm_pkg::MAX_PATH_LEN : len;
        // never let a path claim positions that hold no id yet
        if (eff >= 2 && eff > written_prefix(slot, pos)) len = written_prefix(slot, pos);
        it.op            = gpsm_pkg::OP_LOAD;
        it.path_index    = slot[4:0];
        it.path_position = pos[3:0];
        it.path_length   = len[4:0];
        it.path_image    = img;
        it.hotspot_id    = id;
        it.entry_time    = 63'({$urandom, $urandom});
        it.visit_image   = 16'($urandom);
        return it;
    endfunction

    function automatic gpsm_pkg::t_in_item visit_req(logic [15:0] id, logic [62:0] t_in,
                                                     logic [62:0] t_out, logic [15:0] img);
        gpsm_pkg::t_in_item it;
        it = '0;
        it.op          = gpsm_pkg::OP_VISIT;
        it.hotspot_id  = id;
        it.entry_time  = t_in;
        it.exit_time   = t_out;
        it.visit_image = img;
        it.path_index  = 5'($urandom);
        return it;
    endfunction

    function automatic gpsm_pkg::t_in_item flush_req();
        gpsm_pkg::t_in_item it;
        it = '0;
        it.op = gpsm_pkg::OP_FLUSH;
        return it;
    endfunction

    function automatic logic [15:0] pick_id();
        if ($urandom_range(0, 9) == 0) return 16'($urandom);
        return 16'($urandom_range(0, 3));
    endfunction

    // hands one request to the block, with an optional gap first
    task automatic send_request(gpsm_pkg::t_in_item it);
        int gap;
        if ($urandom_range(0, 99) < in_idle_pct) begin
            gap = $urandom_range(1, 5);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_item  <= it;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        if (it.op == gpsm_pkg::OP_LOAD) path_written[it.path_index][it.path_position] = 1'b1;
        void'(predict_events(it));
        items_sent++;
    endtask

    task automatic drain_events();
        i_in_valid <= 1'b0;
        while (pending_events.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_report_unmatched(bit v);
        i_cfg_valid <= 1'b1;
        i_cfg_data  <= v;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 1'b0;
        report_unmatched = v;
    endtask

    // result monitor and stall generator
    always @(posedge i_clk) begin
        gpsm_pkg::t_out_item want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            events_seen++;
            if (o_out_item.kind == gpsm_pkg::KIND_MATCH) matches_seen++;
            if (o_out_item.kind == gpsm_pkg::KIND_UNMATCHED) unmatched_seen++;
            if (pending_events.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("unexpected event %p", o_out_item);
            end else begin
                want = pending_events.pop_front();
                if (o_out_item !== want) begin
                    mismatches++;
                    if (mismatches <= MAX_REPORTED)
                        $display("event mismatch\n  expected %p\n  actual   %p",
                                 want, o_out_item);
                end
            end
        end
        i_out_stall <= ($urandom_range(0, 99) < out_stall_pct);
    end

    // watchdog
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // directed table row
    typedef struct {
        gpsm_pkg::t_in_item  req;
        bit                  typed;
        gpsm_pkg::t_out_item want;
    } t_row_entry;

    initial begin
        t_row_entry          rows [$];
        t_row_entry          r;
        gpsm_pkg::t_in_item  it;
        gpsm_pkg::t_out_item marker;
        int                  len, slot, sel, base;
        logic [15:0]         img;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_in_item     <= '0;
        i_cfg_valid   <= 1'b0;
        i_cfg_data    <= 1'b0;
        in_idle_pct   = 0;
        out_stall_pct = 0;
        mismatches    = 0;
        items_sent    = 0;
        events_seen   = 0;
        matches_seen  = 0;
        unmatched_seen = 0;
        cycles        = 0;
        window_fill   = 0;
        head_closed   = 1'b0;
        visit_seq     = '0;
        report_unmatched = 1'b0;
        for (int p = 0; p < gpsm_pkg::NUM_PATHS; p++) begin
            path_len_tab[p] = '0;
            path_img_tab[p] = '0;
            path_written[p] = '0;
            for (int i = 0; i < gpsm_pkg::MAX_PATH_LEN; i++) path_id_tab[p][i] = '0;
        end
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed part
        marker = '0;
        marker.kind = gpsm_pkg::KIND_NONE;
        marker.last = 1'b1;
        r.typed = 1'b1; r.want = marker; r.req = flush_req();
        rows.insert(rows.size(), r);
        r.typed = 1'b0; r.req = '1;
        rows.insert(rows.size(), r);
        r.req = load_req(31, 0, 2, 16'hFFFF, 16'hFFFF); path_written[31][0] = 1'b1;
        rows.insert(rows.size(), r);
        r.req = load_req(31, 1, 2, 16'h0000, 16'hFFFF); path_written[31][1] = 1'b1;
        rows.insert(rows.size(), r);
        // short path never matches
        r.req = load_req(0, 15, 1, 16'hFFFF, 16'h0000);
        rows.insert(rows.size(), r);
        // full length path, last element with an overlong length
        for (int i = 0; i < gpsm_pkg::MAX_PATH_LEN; i++) begin
            r.req = load_req(2, i, (i == gpsm_pkg::MAX_PATH_LEN - 1) ? 31 : i + 1,
                             16'h0009, 16'h5A5A);
            path_written[2][i] = 1'b1;
            rows.insert(rows.size(), r);
        end
        r.req = visit_req(16'hFFFF, '1, '1, 16'hFFFF);
        rows.insert(rows.size(), r);
        r.req = visit_req(16'h0000, '0, '0, 16'h0000);
        rows.insert(rows.size(), r);
        r.req = visit_req(16'h1234, 63'h2AAA_5555_0F0F_F0F0, 63'h5555_AAAA_F0F0_0F0F, 16'h00FF);
        rows.insert(rows.size(), r);
        r.req = flush_req();
        rows.insert(rows.size(), r);
        for (int i = 0; i < gpsm_pkg::MAX_PATH_LEN; i++) path_written[i] = '0;
        path_written[0] = '0;

        write_report_unmatched(1'b1);
        foreach (rows[k]) begin
            base = pending_events.size();
            send_request(rows[k].req);
            if (rows[k].typed && pending_events[pending_events.size() - 1] !== rows[k].want) begin
                mismatches++;
                if (mismatches <= MAX_REPORTED)
                    $display("table row %0d\n  expected %p\n  predicts %p",
                             k, rows[k].want, pending_events[$]);
            end
            if (rows[k].req.op == gpsm_pkg::OP_LOAD)
                path_written[rows[k].req.path_index][rows[k].req.path_position] = 1'b1;
        end
        drain_events();

        // random phases: free flow, sender gaps, receiver stalls, light both
        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: begin in_idle_pct = 0;  out_stall_pct = 0;  end
                1: begin in_idle_pct = 62; out_stall_pct = 0;  end
                2: begin in_idle_pct = 0;  out_stall_pct = 62; end
                default: begin in_idle_pct = 6; out_stall_pct = 6; end
            endcase
            write_report_unmatched(ph[0]);
            base = items_sent;
            while (items_sent - base < PHASE_ITEMS) begin
                sel = $urandom_range(0, 99);
                if (sel < 12) begin
                    // complete path
                    slot = $urandom_range(0, gpsm_pkg::NUM_PATHS - 1);
                    len = ($urandom_range(0, 7) == 0) ? $urandom_range(0, gpsm_pkg::MAX_PATH_LEN)
                                                       : $urandom_range(2, 4);
                    img = 16'($urandom);
                    for (int i = 0; i < ((len == 0) ? 1 : len); i++) begin
                        it = load_req(slot, i,
                                      (len == gpsm_pkg::MAX_PATH_LEN && i == len - 1 &&
                                       $urandom_range(0, 1))
                                      ? $urandom_range(17, 31) : len, pick_id(), img);
                        send_request(it);
                    end
                end else if (sel < 15) begin
                    it = load_req($urandom_range(0, 31), $urandom_range(0, 15),
                                  $urandom_range(0, 31), pick_id(), 16'($urandom));
                    send_request(it);
                end else if (sel < 17) begin
                    it = gpsm_pkg::t_in_item'(190'({$urandom, $urandom, $urandom, $urandom,
                                                    $urandom, $urandom, $urandom}));
                    it.op = 2'd3;
                    send_request(it);
                end else if (sel < 22) begin
                    send_request(flush_req());
                end else begin
                    send_request(visit_req(pick_id(), 63'({$urandom, $urandom}),
                                           63'({$urandom, $urandom}), 16'($urandom)));
                end
            end
            send_request(flush_req());
            drain_events();
        end

        $display("covered %0d requests over four flow phases, %0d events checked",
                 items_sent, events_seen);
        $display("(%0d path matches, %0d unmatched visits), %0d mismatches",
                 matches_seen, unmatched_seen, mismatches);
        if (mismatches == 0 && pending_events.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
